// ===== rtl/core/mer_pkg.sv =====
// Shared types and constants for the midpoint ellipse rasterizer.
// Holds the controller-to-datapath command and status structs and the register map.
// No dependencies.
`default_nettype none

package mer_pkg;

    localparam int DEC_W      = 48;
    localparam int PIX_W      = 12;
    localparam int COORD_W    = 10;
    localparam int COLOR_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam int M_TDATA_W  = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COLOR = 2'd2;

    localparam logic [COORD_W-1:0] CENTER_X_RST = 10'd319;
    localparam logic [COORD_W-1:0] CENTER_Y_RST = 10'd239;
    localparam logic [COLOR_W-1:0] COLOR_RST    = 4'd1;

    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    typedef enum logic [2:0] {
        A_AXIS_A,
        A_AXIS_B,
        A_ASQ,
        A_BSQ,
        A_PROD
    } mul_a_sel_t;

    typedef enum logic [3:0] {
        B_ONE,
        B_THREE,
        B_AXIS_A,
        B_AXIS_B,
        B_Y,
        B_Y_M1,
        B_TWO_Y_M1,
        B_X_P1,
        B_TWO_X_P1,
        B_TWO_X_P2,
        B_TWO_X_P3
    } mul_b_sel_t;

    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB,
        ACC_ASQ,
        ACC_BSQ,
        ACC_TMP
    } acc_op_t;

    typedef struct packed {
        mul_a_sel_t  a_sel;
        mul_b_sel_t  b_sel;
        acc_op_t     acc_op;
        logic [1:0]  acc_sh;
        logic        load_axes;
        logic        x_inc;
        logic        y_dec;
        logic        out_load;
        logic [1:0]  quad;
    } mer_cmd_t;

    typedef struct packed {
        logic dec_neg;
        logic left_gt;
        logic y_zero;
        logic out_free;
    } mer_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/midpoint_ellipse_rasterizer.sv =====
// Top level of the midpoint ellipse rasterizer: stream ports, configuration port,
// controller and datapath. Depends on mer_pkg, mer_ctrl and mer_dp.
`default_nettype none

// A start transaction (tuser 0) latches the semi-axes a and b and emits the four
// symmetric pixels of point (0,b) around the configured centre; each advance
// transaction (tuser 1) steps one point of the quadrant walk and emits its four
// pixels, tlast on the fourth and tuser on all pixels of the final point (y = 0).
// Advances while no walk is running are taken and dropped. All decision arithmetic
// runs on one shared multiplier (at least 48 by AXIS_BITS+2 bits) followed by a
// registered accumulate stage. A start, a region 1 step, a region 2 step and the
// step that crosses into region 2 (which also computes the region 2 decision) each
// hold the block until their fourth pixel is loaded, so no new item is taken before
// then. The last pixel of one item can still wait in the output register while the
// next item is taken. Configuration writes are accepted every cycle; indices beyond
// the pixel colour are ignored.
module midpoint_ellipse_rasterizer #(
    parameter int AXIS_BITS = 10
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   s_tvalid,
    output logic                                  s_tready,
    // semi_axis_x, semi_axis_y, zero padding
    input  wire  [((2*AXIS_BITS+7)/8)*8-1:0]      s_tdata,
    // opcode
    input  wire                                   s_tuser,
    output logic                                  m_tvalid,
    input  wire                                   m_tready,
    // pixel_x, pixel_y, color, zero padding
    output logic [mer_pkg::M_TDATA_W-1:0]         m_tdata,
    output logic                                  m_tlast,
    // curve_done
    output logic                                  m_tuser,
    input  wire                                   cfg_valid,
    output logic                                  cfg_ready,
    input  wire  [mer_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire  [mer_pkg::CFG_DATA_W-1:0]        cfg_data
);

    mer_pkg::mer_cmd_t cmd;
    mer_pkg::mer_sts_t sts;

    logic [AXIS_BITS-1:0] semi_axis_x, semi_axis_y;

    assign semi_axis_x = s_tdata[AXIS_BITS-1:0];
    assign semi_axis_y = s_tdata[2*AXIS_BITS-1:AXIS_BITS];
    assign cfg_ready   = 1'b1;

    mer_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_opcode (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    mer_dp #(
        .AXIS_BITS (AXIS_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .semi_axis_x (semi_axis_x),
        .semi_axis_y (semi_axis_y),
        .cmd         (cmd),
        .sts         (sts),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    a_load_into_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("pixel loaded over a pending transaction");

    a_y_never_below_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.y_dec |-> !sts.y_zero)
        else $error("point y stepped below zero");

    a_no_emit_when_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !cmd.out_load)
        else $error("pixel emitted while accepting input");

    a_walk_end: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_axes |=> !cmd.out_load)
        else $error("emission started before start arithmetic");

endmodule

`default_nettype wire

// ===== rtl/core/mer_dp.sv =====
// Datapath of the midpoint ellipse rasterizer: configuration registers, point and
// decision registers, shared multiplier with accumulate stage, and pixel output register.
// Depends on mer_pkg.
`default_nettype none

module mer_dp #(
    parameter int AXIS_BITS = 10
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               cfg_wr,
    input  wire  [mer_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [mer_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire  [AXIS_BITS-1:0]              semi_axis_x,
    input  wire  [AXIS_BITS-1:0]              semi_axis_y,
    input  wire  mer_pkg::mer_cmd_t           cmd,
    output mer_pkg::mer_sts_t                 sts,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [mer_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                              m_tlast,
    output logic                              m_tuser
);

    localparam int SQ_W   = 2 * AXIS_BITS;
    localparam int OPB_W  = AXIS_BITS + 2;
    localparam int CMP_W  = 3 * AXIS_BITS + 2;
    localparam int PROD_W = (CMP_W > mer_pkg::DEC_W) ? CMP_W : mer_pkg::DEC_W;
    localparam int PAD_W  = mer_pkg::M_TDATA_W - 2 * mer_pkg::PIX_W - mer_pkg::COLOR_W;

    logic [mer_pkg::COORD_W-1:0] center_x_reg, center_y_reg;
    logic [mer_pkg::COLOR_W-1:0] color_reg;

    logic [AXIS_BITS-1:0]        axis_a_reg, axis_b_reg;
    logic [AXIS_BITS-1:0]        point_x_reg, point_y_reg;
    logic [SQ_W-1:0]             asq_reg, bsq_reg;
    logic [PROD_W-1:0]           prod_reg, tmp_reg;
    logic [mer_pkg::DEC_W-1:0]   dec_reg;
    mer_pkg::acc_op_t            acc_op_reg;
    logic [1:0]                  acc_sh_reg;

    logic [PROD_W-1:0]           op_a;
    logic [OPB_W-1:0]            op_b, x_ext, y_ext;
    logic [PROD_W-1:0]           prod_next;
    logic [mer_pkg::DEC_W-1:0]   term;

    logic                        m_tvalid_reg;
    logic [mer_pkg::PIX_W-1:0]   m_pixel_x_reg, m_pixel_y_reg;
    logic [mer_pkg::COLOR_W-1:0] m_color_reg;
    logic                        m_last_reg, m_done_reg;

    logic [mer_pkg::PIX_W-1:0]   x_pix, y_pix, cx_pix, cy_pix, pix_x_next, pix_y_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg <= mer_pkg::CENTER_X_RST;
            center_y_reg <= mer_pkg::CENTER_Y_RST;
            color_reg    <= mer_pkg::COLOR_RST;
        end else if (cfg_wr) begin
            unique case (cfg_index)
                mer_pkg::CFG_CENTER_X:    center_x_reg <= cfg_data;
                mer_pkg::CFG_CENTER_Y:    center_y_reg <= cfg_data;
                mer_pkg::CFG_PIXEL_COLOR: color_reg    <= cfg_data[mer_pkg::COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    assign x_ext = OPB_W'(point_x_reg);
    assign y_ext = OPB_W'(point_y_reg);

    always_comb begin
        unique case (cmd.a_sel)
            mer_pkg::A_AXIS_A: op_a = PROD_W'(axis_a_reg);
            mer_pkg::A_AXIS_B: op_a = PROD_W'(axis_b_reg);
            mer_pkg::A_ASQ:    op_a = PROD_W'(asq_reg);
            mer_pkg::A_BSQ:    op_a = PROD_W'(bsq_reg);
            mer_pkg::A_PROD:   op_a = prod_reg;
            default:           op_a = '0;
        endcase
    end

    always_comb begin
        unique case (cmd.b_sel)
            mer_pkg::B_ONE:      op_b = OPB_W'(1);
            mer_pkg::B_THREE:    op_b = OPB_W'(3);
            mer_pkg::B_AXIS_A:   op_b = OPB_W'(axis_a_reg);
            mer_pkg::B_AXIS_B:   op_b = OPB_W'(axis_b_reg);
            mer_pkg::B_Y:        op_b = y_ext;
            mer_pkg::B_Y_M1:     op_b = y_ext - OPB_W'(1);
            mer_pkg::B_TWO_Y_M1: op_b = (y_ext << 1) - OPB_W'(1);
            mer_pkg::B_X_P1:     op_b = x_ext + OPB_W'(1);
            mer_pkg::B_TWO_X_P1: op_b = (x_ext << 1) + OPB_W'(1);
            mer_pkg::B_TWO_X_P2: op_b = (x_ext << 1) + OPB_W'(2);
            mer_pkg::B_TWO_X_P3: op_b = (x_ext << 1) + OPB_W'(3);
            default:             op_b = '0;
        endcase
    end

    assign prod_next = op_a * PROD_W'(op_b);
    assign term      = mer_pkg::DEC_W'(prod_reg) << acc_sh_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        if (acc_op_reg == mer_pkg::ACC_TMP) begin
            tmp_reg <= prod_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_op_reg <= mer_pkg::ACC_NONE;
            acc_sh_reg <= 2'd0;
            dec_reg    <= '0;
            asq_reg    <= '0;
            bsq_reg    <= '0;
        end else begin
            acc_op_reg <= cmd.acc_op;
            acc_sh_reg <= cmd.acc_sh;
            unique case (acc_op_reg)
                mer_pkg::ACC_LOAD: dec_reg <= term;
                mer_pkg::ACC_ADD:  dec_reg <= dec_reg + term;
                mer_pkg::ACC_SUB:  dec_reg <= dec_reg - term;
                mer_pkg::ACC_ASQ:  asq_reg <= SQ_W'(prod_reg);
                mer_pkg::ACC_BSQ:  bsq_reg <= SQ_W'(prod_reg);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_x_reg <= '0;
            point_y_reg <= '0;
        end else if (cmd.load_axes) begin
            point_x_reg <= '0;
            point_y_reg <= semi_axis_y;
        end else begin
            if (cmd.x_inc) begin
                point_x_reg <= point_x_reg + AXIS_BITS'(1);
            end
            if (cmd.y_dec) begin
                point_y_reg <= point_y_reg - AXIS_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_axes) begin
            axis_a_reg <= semi_axis_x;
            axis_b_reg <= semi_axis_y;
        end
    end

    assign x_pix  = mer_pkg::PIX_W'(point_x_reg);
    assign y_pix  = mer_pkg::PIX_W'(point_y_reg);
    assign cx_pix = mer_pkg::PIX_W'(center_x_reg);
    assign cy_pix = mer_pkg::PIX_W'(center_y_reg);

    // quadrant order: (+x,+y), (+x,-y), (-x,-y), (-x,+y)
    assign pix_x_next = cmd.quad[1] ? cx_pix - x_pix : cx_pix + x_pix;
    assign pix_y_next = (cmd.quad[1] ^ cmd.quad[0]) ? cy_pix - y_pix : cy_pix + y_pix;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_pixel_x_reg <= pix_x_next;
            m_pixel_y_reg <= pix_y_next;
            m_color_reg   <= color_reg;
            m_last_reg    <= &cmd.quad;
            m_done_reg    <= (point_y_reg == '0);
        end
    end

    assign sts.dec_neg  = dec_reg[mer_pkg::DEC_W-1];
    assign sts.left_gt  = tmp_reg > (prod_reg << 1);
    assign sts.y_zero   = (point_y_reg == '0);
    assign sts.out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, m_color_reg, m_pixel_y_reg, m_pixel_x_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_done_reg;

endmodule

`default_nettype wire

// ===== rtl/core/mer_ctrl.sv =====
// Controller of the midpoint ellipse rasterizer: sequences multiplier operations for
// start, region 1 and region 2 steps, then drives the four-pixel emission.
// Depends on mer_pkg.
`default_nettype none

module mer_ctrl (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_tvalid,
    output logic               s_tready,
    input  wire                s_opcode,
    input  wire mer_pkg::mer_sts_t sts,
    output mer_pkg::mer_cmd_t  cmd
);

    typedef enum logic [4:0] {
        IDLE,
        ST_ASQ,
        ST_BSQ,
        ST_D0,
        ST_D1,
        ST_D2,
        R1_L,
        R1_R,
        R1_TEST,
        R1_B,
        R1_A1,
        R1_A2,
        R2_I0,
        R2_I1,
        R2_I2,
        R2_I3,
        R2_I4,
        R2_I5,
        R2_WAIT,
        R2_TEST,
        R2_B,
        R2_A1,
        R2_A2,
        EMIT
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] quad_reg, quad_next;
    logic       walk_reg, walk_next;
    logic       region2_reg, region2_next;
    logic       neg_reg, neg_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            quad_reg    <= 2'd0;
            walk_reg    <= 1'b0;
            region2_reg <= 1'b0;
            neg_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            quad_reg    <= quad_next;
            walk_reg    <= walk_next;
            region2_reg <= region2_next;
            neg_reg     <= neg_next;
        end
    end

    assign s_tready = (state_reg == IDLE);

    always_comb begin
        state_next   = state_reg;
        quad_next    = quad_reg;
        walk_next    = walk_reg;
        region2_next = region2_reg;
        neg_next     = neg_reg;

        cmd           = '0;
        cmd.a_sel     = mer_pkg::A_ASQ;
        cmd.b_sel     = mer_pkg::B_ONE;
        cmd.acc_op    = mer_pkg::ACC_NONE;
        cmd.acc_sh    = 2'd0;
        cmd.quad      = quad_reg;

        unique case (state_reg)
            IDLE: begin
                if (s_tvalid) begin
                    if (s_opcode == mer_pkg::OP_START) begin
                        cmd.load_axes = 1'b1;
                        region2_next  = 1'b0;
                        quad_next     = 2'd0;
                        state_next    = ST_ASQ;
                    end else if (walk_reg) begin
                        state_next = region2_reg ? R2_TEST : R1_L;
                    end
                end
            end
            ST_ASQ: begin
                cmd.a_sel  = mer_pkg::A_AXIS_A;
                cmd.b_sel  = mer_pkg::B_AXIS_A;
                cmd.acc_op = mer_pkg::ACC_ASQ;
                state_next = ST_BSQ;
            end
            ST_BSQ: begin
                cmd.a_sel  = mer_pkg::A_AXIS_B;
                cmd.b_sel  = mer_pkg::B_AXIS_B;
                cmd.acc_op = mer_pkg::ACC_BSQ;
                state_next = ST_D0;
            end
            ST_D0: begin
                cmd.a_sel  = mer_pkg::A_ASQ;
                cmd.b_sel  = mer_pkg::B_ONE;
                cmd.acc_op = mer_pkg::ACC_LOAD;
                state_next = ST_D1;
            end
            ST_D1: begin
                cmd.a_sel  = mer_pkg::A_ASQ;
                cmd.b_sel  = mer_pkg::B_AXIS_B;
                cmd.acc_op = mer_pkg::ACC_SUB;
                cmd.acc_sh = 2'd2;
                state_next = ST_D2;
            end
            ST_D2: begin
                cmd.a_sel  = mer_pkg::A_BSQ;
                cmd.b_sel  = mer_pkg::B_ONE;
                cmd.acc_op = mer_pkg::ACC_ADD;
                cmd.acc_sh = 2'd2;
                state_next = EMIT;
            end
            R1_L: begin
                cmd.a_sel  = mer_pkg::A_ASQ;
                cmd.b_sel  = mer_pkg::B_TWO_Y_M1;
                cmd.acc_op = mer_pkg::ACC_TMP;
                state_next = R1_R;
            end
            R1_R: begin
                cmd.a_sel  = mer_pkg::A_BSQ;
                cmd.b_sel  = mer_pkg::B_X_P1;
                state_next = R1_TEST;
            end
            R1_TEST: begin
                neg_next = sts.dec_neg;
                if (sts.left_gt) begin
                    state_next = R1_B;
                end else begin
                    region2_next = 1'b1;
                    state_next   = R2_I0;
                end
            end
            R1_B: begin
                cmd.a_sel  = mer_pkg::A_BSQ;
                cmd.b_sel  = mer_pkg::B_TWO_X_P3;
                cmd.acc_op = mer_pkg::ACC_ADD;
                cmd.acc_sh = 2'd2;
                if (neg_reg) begin
                    cmd.x_inc  = 1'b1;
                    state_next = EMIT;
                end else begin
                    state_next = R1_A1;
                end
            end
            R1_A1: begin
                cmd.a_sel  = mer_pkg::A_ASQ;
                cmd.b_sel  = mer_pkg::B_ONE;
                cmd.acc_op = mer_pkg::ACC_ADD;
                cmd.acc_sh = 2'd3;
                state_next = R1_A2;
            end
            R1_A2: begin
                cmd.a_sel  = mer_pkg::A_ASQ;
                cmd.b_sel  = mer_pkg::B_Y;
                cmd.acc_op = mer_pkg::ACC_SUB;
                cmd.acc_sh = 2'd3;
                cmd.x_inc  = 1'b1;
                cmd.y_dec  = 1'b1;
                state_next = EMIT;
            end
            R2_I0: begin
                cmd.a_sel  = mer_pkg::A_BSQ;
                cmd.b_sel  = mer_pkg::B_TWO_X_P1;
                state_next = R2_I1;
            end
            R2_I1: begin
                cmd.a_sel  = mer_pkg::A_PROD;
                cmd.b_sel  = mer_pkg::B_TWO_X_P1;
                cmd.acc_op = mer_pkg::ACC_LOAD;
                state_next = R2_I2;
            end
            R2_I2: begin
                cmd.a_sel  = mer_pkg::A_ASQ;
                cmd.b_sel  = mer_pkg::B_Y_M1;
                state_next = R2_I3;
            end
            R2_I3: begin
                cmd.a_sel  = mer_pkg::A_PROD;
                cmd.b_sel  = mer_pkg::B_Y_M1;
                cmd.acc_op = mer_pkg::ACC_ADD;
                cmd.acc_sh = 2'd2;
                state_next = R2_I4;
            end
            R2_I4: begin
                cmd.a_sel  = mer_pkg::A_ASQ;
                cmd.b_sel  = mer_pkg::B_AXIS_B;
                state_next = R2_I5;
            end
            R2_I5: begin
                cmd.a_sel  = mer_pkg::A_PROD;
                cmd.b_sel  = mer_pkg::B_AXIS_B;
                cmd.acc_op = mer_pkg::ACC_SUB;
                cmd.acc_sh = 2'd2;
                state_next = R2_WAIT;
            end
            R2_WAIT: begin
                state_next = R2_TEST;
            end
            R2_TEST: begin
                neg_next   = sts.dec_neg;
                state_next = sts.dec_neg ? R2_B : R2_A1;
            end
            R2_B: begin
                cmd.a_sel  = mer_pkg::A_BSQ;
                cmd.b_sel  = mer_pkg::B_TWO_X_P2;
                cmd.acc_op = mer_pkg::ACC_ADD;
                cmd.acc_sh = 2'd2;
                state_next = R2_A1;
            end
            R2_A1: begin
                cmd.a_sel  = mer_pkg::A_ASQ;
                cmd.b_sel  = mer_pkg::B_THREE;
                cmd.acc_op = mer_pkg::ACC_ADD;
                cmd.acc_sh = 2'd2;
                state_next = R2_A2;
            end
            R2_A2: begin
                cmd.a_sel  = mer_pkg::A_ASQ;
                cmd.b_sel  = mer_pkg::B_Y;
                cmd.acc_op = mer_pkg::ACC_SUB;
                cmd.acc_sh = 2'd3;
                cmd.x_inc  = neg_reg;
                cmd.y_dec  = 1'b1;
                state_next = EMIT;
            end
            EMIT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    quad_next    = quad_reg + 2'd1;
                    if (&quad_reg) begin
                        walk_next  = !sts.y_zero;
                        state_next = IDLE;
                    end
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
